### rtl/tdlft_pkg.sv
// ----------------------------------------------------------------------------
// tdlft_pkg
// Shared types and constants for the tick divider / LED flash timer.
// ----------------------------------------------------------------------------
package tdlft_pkg;

   localparam int unsigned CountWidth  = 8;
   localparam int unsigned CmdWidth    = 3;
   localparam int unsigned CsrIdxWidth = 2;

   // command codes; six and seven are unused and do nothing
   localparam logic [CmdWidth-1:0] CMD_TICK          = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_START_TX      = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_START_RX      = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_RX_SUCCESS    = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_START_LED     = 3'd4;
   localparam logic [CmdWidth-1:0] CMD_LOAD_SHUTDOWN = 3'd5;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_FAST_TICKS_PER_SLOW = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_TX_PACING_LIMIT     = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_POWER_ON_SLOW_TICKS = 2'd2;

   localparam logic [CountWidth-1:0] FAST_TICKS_PER_SLOW_RESET = 8'd50;
   localparam logic [CountWidth-1:0] TX_PACING_LIMIT_RESET     = 8'd5;
   localparam logic [CountWidth-1:0] POWER_ON_SLOW_TICKS_RESET = 8'd30;

   typedef struct packed {
      logic [CmdWidth-1:0]   command;
      logic [CountWidth-1:0] first_value;
      logic [CountWidth-1:0] second_value;
      logic [CountWidth-1:0] flash_period;
   } item_type;

   // input stage to engine: item moves on this cycle
   typedef struct packed {
      logic     fire;
      item_type item;
   } stage_type;

   typedef struct packed {
      logic                   write_enable;
      logic [CsrIdxWidth-1:0] index;
      logic [CountWidth-1:0]  write_data;
   } csr_write_type;

   typedef struct packed {
      logic slow_tick;
      logic power_on_done;
      logic tx_busy;
      logic rx_active;
      logic led_sequence_active;
      logic led_flash;
      logic led_change;
      logic shutdown_due;
   } result_type;

   typedef struct packed {
      logic [CountWidth-1:0] prescale_count;
      logic [CountWidth-1:0] tx_pacing_count;
      logic                  tx_busy_flag;
      logic [CountWidth-1:0] rx_timeout_count;
      logic                  rx_active_flag;
      logic                  rx_success_flag;
      logic [CountWidth-1:0] power_on_count;
      logic                  power_on_flag;
      logic                  led_active_flag;
      logic                  led_delay_done;
      logic [CountWidth-1:0] led_delay_count;
      logic [CountWidth-1:0] led_period_count;
      logic [CountWidth-1:0] led_period;
      logic [CountWidth-1:0] toggles_left;
      logic                  flash_phase;
      logic                  change_phase;
      logic [CountWidth-1:0] shutdown_count;
      logic                  shutdown_flag;
   } state_type;

endpackage

### rtl/tdlft_if.sv
// ----------------------------------------------------------------------------
// tdlft_req_if / tdlft_rsp_if
// Valid/ready channels for command items and status results.
// ----------------------------------------------------------------------------
interface tdlft_req_if;
   logic                             valid;
   logic                             ready;
   logic [tdlft_pkg::CmdWidth-1:0]   command;
   logic [tdlft_pkg::CountWidth-1:0] first_value;
   logic [tdlft_pkg::CountWidth-1:0] second_value;
   logic [tdlft_pkg::CountWidth-1:0] flash_period;

   modport source (output valid, command, first_value, second_value, flash_period,
                   input ready);
   modport sink   (input valid, command, first_value, second_value, flash_period,
                   output ready);
endinterface

interface tdlft_rsp_if;
   logic valid;
   logic ready;
   logic slow_tick;
   logic power_on_done;
   logic tx_busy;
   logic rx_active;
   logic led_sequence_active;
   logic led_flash;
   logic led_change;
   logic shutdown_due;

   modport source (output valid, slow_tick, power_on_done, tx_busy, rx_active,
                   led_sequence_active, led_flash, led_change, shutdown_due,
                   input ready);
   modport sink   (input valid, slow_tick, power_on_done, tx_busy, rx_active,
                   led_sequence_active, led_flash, led_change, shutdown_due,
                   output ready);
endinterface

### rtl/tick_divider_led_flash_timer.sv
// ----------------------------------------------------------------------------
// tick_divider_led_flash_timer
// Fast-tick prescaler with transmit pacing, receive timeout, power-on delay,
// LED flash sequencer and shutdown countdown; one status result per command.
// ----------------------------------------------------------------------------
//
//  channel   dir  transfer when         carries
//  --------  ---  --------------------  ----------------------------------------
//  req_chan  in   valid && ready        command, first_value, second_value,
//                                       flash_period
//  rsp_chan  out  valid && ready        slow_tick and seven status flags
//  csr_*     in   csr_write_enable      index 0..2, 8-bit settings write
//
//  Each command is held in the input register and is folded into the timer
//  state on its way into the result register; one transfer per cycle is
//  sustained while the status channel takes every result.
//  The result register moves whenever it is empty or being taken, so a
//  waiting result never blocks the next input transfer by itself.
//  Synchronous reset clears all counters and flags and loads the settings
//  defaults (50, 5, 30).
//  Settings must be written only while nothing is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module tick_divider_led_flash_timer (
   input  logic                                clock,
   input  logic                                reset,
   tdlft_req_if.sink                           req_chan,
   tdlft_rsp_if.source                         rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [tdlft_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [tdlft_pkg::CountWidth-1:0]    csr_write_data
);

   tdlft_pkg::stage_type     stage;       // item leaving the input register
   tdlft_pkg::result_type    result;      // status computed for that item
   tdlft_pkg::csr_write_type csr;
   logic                     out_can_load;

   assign csr = '{write_enable: csr_write_enable,
                  index:        csr_index,
                  write_data:   csr_write_data};

   // input register
   tdlft_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .out_can_load (out_can_load),
      .stage        (stage)
   );

   // state update, settings
   tdlft_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .csr    (csr),
      .result (result)
   );

   // result register
   tdlft_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (stage.fire),
      .result   (result),
      .can_load (out_can_load),
      .rsp_chan (rsp_chan)
   );

   // an item only moves on when the result register has room for it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      stage.fire |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result overwritten before transfer");

   // a result appears in the cycle after an item leaves the input register
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      stage.fire |=> rsp_chan.valid)
      else $error("result missing after item");

endmodule

### rtl/tdlft_in_reg.sv
// ----------------------------------------------------------------------------
// tdlft_in_reg
// Input register: holds one command item until the engine takes it.
// ----------------------------------------------------------------------------
module tdlft_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   tdlft_req_if.sink             req_chan,
   input  logic                  out_can_load,
   output tdlft_pkg::stage_type  stage
);

   logic                 valid_ff;
   logic                 valid_in;
   tdlft_pkg::item_type  item_ff;
   logic                 take;

   assign take           = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !valid_ff || out_can_load;
   assign stage.fire     = valid_ff && out_can_load;
   assign stage.item     = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (stage.fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{command:      req_chan.command,
                      first_value:  req_chan.first_value,
                      second_value: req_chan.second_value,
                      flash_period: req_chan.flash_period};
      end
   end

endmodule

### rtl/tdlft_engine.sv
// ----------------------------------------------------------------------------
// tdlft_engine
// Timer state, settings registers and the per-item update.
// ----------------------------------------------------------------------------
module tdlft_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  tdlft_pkg::stage_type     stage,
   input  tdlft_pkg::csr_write_type csr,
   output tdlft_pkg::result_type    result
);

   logic [tdlft_pkg::CountWidth-1:0] fast_ticks_ff;
   logic [tdlft_pkg::CountWidth-1:0] pacing_limit_ff;
   logic [tdlft_pkg::CountWidth-1:0] power_on_ticks_ff;

   tdlft_pkg::state_type state_ff;
   tdlft_pkg::state_type state_in;
   logic                 slow;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ticks_ff     <= tdlft_pkg::FAST_TICKS_PER_SLOW_RESET;
         pacing_limit_ff   <= tdlft_pkg::TX_PACING_LIMIT_RESET;
         power_on_ticks_ff <= tdlft_pkg::POWER_ON_SLOW_TICKS_RESET;
      end else if (csr.write_enable) begin
         unique case (csr.index)
            tdlft_pkg::CSR_FAST_TICKS_PER_SLOW: fast_ticks_ff     <= csr.write_data;
            tdlft_pkg::CSR_TX_PACING_LIMIT:     pacing_limit_ff   <= csr.write_data;
            tdlft_pkg::CSR_POWER_ON_SLOW_TICKS: power_on_ticks_ff <= csr.write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [tdlft_pkg::CountWidth-1:0] pre;
      logic [tdlft_pkg::CountWidth-1:0] pwr;
      logic [tdlft_pkg::CountWidth-1:0] per;
      tdlft_pkg::state_type n;
      n    = state_ff;
      slow = 1'b0;
      pre  = state_ff.prescale_count + 8'd1;
      pwr  = state_ff.power_on_count + 8'd1;
      per  = state_ff.led_period_count + 8'd1;

      unique case (stage.item.command)
         tdlft_pkg::CMD_TICK: begin
            n.prescale_count = pre;
            if (fast_ticks_ff <= pre) begin
               n.prescale_count = '0;
               slow             = 1'b1;

               // transmit pacing
               if (pacing_limit_ff >= state_ff.tx_pacing_count) begin
                  n.tx_pacing_count = state_ff.tx_pacing_count + 8'd1;
               end else begin
                  n.tx_busy_flag = 1'b0;
               end

               // receive timeout, frozen once success is signalled
               if (!state_ff.rx_success_flag && state_ff.rx_active_flag) begin
                  if (state_ff.rx_timeout_count != '0) begin
                     n.rx_timeout_count = state_ff.rx_timeout_count - 8'd1;
                  end else begin
                     n.rx_active_flag = 1'b0;
                  end
               end

               // power-on period
               if (!state_ff.power_on_flag) begin
                  n.power_on_count = pwr;
                  if (power_on_ticks_ff <= pwr) begin
                     n.power_on_count = '0;
                     n.power_on_flag  = 1'b1;
                  end
               end

               // LED sequence, or shutdown countdown when idle
               if (state_ff.led_active_flag) begin
                  if (!state_ff.led_delay_done) begin
                     if (state_ff.led_delay_count != '0) begin
                        n.led_delay_count = state_ff.led_delay_count - 8'd1;
                     end else begin
                        n.led_delay_done = 1'b1;
                     end
                  end
                  if (n.led_delay_done) begin
                     n.led_period_count = per;
                     if (state_ff.led_period <= per) begin
                        n.led_period_count = '0;
                        if (state_ff.toggles_left != '0) begin
                           n.flash_phase  = !state_ff.flash_phase;
                           n.change_phase = state_ff.change_phase ^ n.flash_phase;
                           n.toggles_left = state_ff.toggles_left - 8'd1;
                        end else begin
                           n.led_delay_done  = 1'b0;
                           n.led_active_flag = 1'b0;
                           n.flash_phase     = 1'b0;
                           n.change_phase    = 1'b0;
                        end
                     end
                  end
               end else begin
                  if (state_ff.shutdown_count != '0) begin
                     n.shutdown_count = state_ff.shutdown_count - 8'd1;
                     n.shutdown_flag  = 1'b0;
                     n.flash_phase    = 1'b0;
                  end else begin
                     n.shutdown_flag = 1'b1;
                  end
               end
            end
         end
         tdlft_pkg::CMD_START_TX: begin
            n.tx_pacing_count = '0;
            n.tx_busy_flag    = 1'b1;
         end
         tdlft_pkg::CMD_START_RX: begin
            n.rx_timeout_count = stage.item.first_value;
            n.rx_active_flag   = 1'b1;
            n.rx_success_flag  = 1'b0;
         end
         tdlft_pkg::CMD_RX_SUCCESS: begin
            n.rx_success_flag = 1'b1;
         end
         tdlft_pkg::CMD_START_LED: begin
            n.led_active_flag  = 1'b1;
            n.led_delay_done   = 1'b0;
            n.led_delay_count  = stage.item.first_value;
            n.toggles_left     = stage.item.second_value;
            n.led_period       = stage.item.flash_period;
            n.led_period_count = '0;
            n.flash_phase      = 1'b0;
            n.change_phase     = 1'b0;
         end
         tdlft_pkg::CMD_LOAD_SHUTDOWN: begin
            n.shutdown_count = stage.item.first_value;
         end
         default: ;
      endcase
      state_in = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (stage.fire) begin
         state_ff <= state_in;
      end
   end

   // status after this item
   assign result = '{slow_tick:           slow,
                     power_on_done:       state_in.power_on_flag,
                     tx_busy:             state_in.tx_busy_flag,
                     rx_active:           state_in.rx_active_flag,
                     led_sequence_active: state_in.led_active_flag,
                     led_flash:           state_in.flash_phase,
                     led_change:          state_in.change_phase,
                     shutdown_due:        state_in.shutdown_flag};

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !stage.fire |=> $stable(state_ff))
      else $error("timer state changed with no item");

   a_power_on_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.power_on_flag |=> state_ff.power_on_flag)
      else $error("power-on flag cleared");

   a_led_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !state_ff.led_active_flag |->
         (!state_ff.flash_phase && !state_ff.change_phase && !state_ff.led_delay_done))
      else $error("LED phase set with no sequence running");

   a_slow_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      slow |-> (stage.item.command == tdlft_pkg::CMD_TICK))
      else $error("slow tick from a non-tick command");

endmodule

### rtl/tdlft_out_reg.sv
// ----------------------------------------------------------------------------
// tdlft_out_reg
// Result register driving the status channel.
// ----------------------------------------------------------------------------
module tdlft_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  tdlft_pkg::result_type  result,
   output logic                   can_load,
   tdlft_rsp_if.source            rsp_chan
);

   logic                  valid_ff;
   logic                  valid_in;
   tdlft_pkg::result_type result_ff;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid               = valid_ff;
   assign rsp_chan.slow_tick           = result_ff.slow_tick;
   assign rsp_chan.power_on_done       = result_ff.power_on_done;
   assign rsp_chan.tx_busy             = result_ff.tx_busy;
   assign rsp_chan.rx_active           = result_ff.rx_active;
   assign rsp_chan.led_sequence_active = result_ff.led_sequence_active;
   assign rsp_chan.led_flash           = result_ff.led_flash;
   assign rsp_chan.led_change          = result_ff.led_change;
   assign rsp_chan.shutdown_due        = result_ff.shutdown_due;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tick divider / LED flash timer. Commands are
// pushed through the request channel with random gaps; every status transfer
// is checked field by field against an in-bench timer model fed on accept.
// ----------------------------------------------------------------------------
module tb;
   import tdlft_pkg::*;

   // spare command codes: accepted, answered, no effect on the timers
   localparam logic [CmdWidth-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CmdWidth-1:0] CMD_SPARE_HI = 3'd7;

   localparam int unsigned SETTLE_CYCLES = 8;       // pipe is two deep, allow margin
   localparam int unsigned CYCLE_LIMIT   = 400000;  // far beyond the slowest run
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct {
      bit [CountWidth-1:0] prescale;
      bit [CountWidth-1:0] pacing;
      bit [CountWidth-1:0] rx_left;
      bit [CountWidth-1:0] power_count;
      bit [CountWidth-1:0] delay_left;
      bit [CountWidth-1:0] period_count;
      bit [CountWidth-1:0] period;
      bit [CountWidth-1:0] toggles;
      bit [CountWidth-1:0] shutdown_left;
      bit                  tx_busy;
      bit                  rx_active;
      bit                  rx_success;
      bit                  power_done;
      bit                  led_active;
      bit                  delay_done;
      bit                  flash;
      bit                  change;
      bit                  shutdown_due;
   } timer_state_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_enable;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CountWidth-1:0]  csr_write_data;

   tdlft_req_if req_chan ();
   tdlft_rsp_if rsp_chan ();

   tick_divider_led_flash_timer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // timer model and its copy of the settings
   timer_state_type     tmr = '{default: 0};
   bit [CountWidth-1:0] ticks_per_slow = FAST_TICKS_PER_SLOW_RESET;
   bit [CountWidth-1:0] pacing_limit   = TX_PACING_LIMIT_RESET;
   bit [CountWidth-1:0] power_on_ticks = POWER_ON_SLOW_TICKS_RESET;

   item_type    pending_cmds [$];
   result_type  expected_status [$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   bit          steady      = 1'b0;   // no gaps and no stalls while set
   int unsigned send_gap;
   int unsigned stall_left;

   // bit order of result_type, LSB first
   string status_fields [8] = '{"shutdown_due", "led_change", "led_flash",
                                "led_sequence_active", "rx_active", "tx_busy",
                                "power_on_done", "slow_tick"};

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Timer model
   // ------------------------------------------------------------------------

   // one slow tick: pacing, rx timeout, power-on, LED sequence or shutdown
   function automatic void advance_slow_tick();
      // pacing limit of 255 never trips: the counter just wraps
      if (pacing_limit >= tmr.pacing)
         tmr.pacing = tmr.pacing + 8'd1;
      else
         tmr.tx_busy = 1'b0;

      // rx success freezes the countdown
      if (!tmr.rx_success && tmr.rx_active) begin
         if (tmr.rx_left != 0)
            tmr.rx_left = tmr.rx_left - 8'd1;
         else
            tmr.rx_active = 1'b0;
      end

      // limit zero behaves as one since the count is bumped first
      if (!tmr.power_done) begin
         tmr.power_count = tmr.power_count + 8'd1;
         if (power_on_ticks <= tmr.power_count) begin
            tmr.power_count = '0;
            tmr.power_done  = 1'b1;
         end
      end

      if (tmr.led_active) begin
         if (!tmr.delay_done) begin
            if (tmr.delay_left != 0)
               tmr.delay_left = tmr.delay_left - 8'd1;
            else
               tmr.delay_done = 1'b1;
         end
         // delay end and first period step fall on the same slow tick
         if (tmr.delay_done) begin
            tmr.period_count = tmr.period_count + 8'd1;
            if (tmr.period <= tmr.period_count) begin
               tmr.period_count = '0;
               if (tmr.toggles != 0) begin
                  tmr.flash = !tmr.flash;
                  if (tmr.flash)
                     tmr.change = !tmr.change;
                  tmr.toggles = tmr.toggles - 8'd1;
               end else begin
                  // budget spent: sequence ends, phases drop
                  tmr.delay_done = 1'b0;
                  tmr.led_active = 1'b0;
                  tmr.flash      = 1'b0;
                  tmr.change     = 1'b0;
               end
            end
         end
      end else begin
         if (tmr.shutdown_left != 0) begin
            tmr.shutdown_left = tmr.shutdown_left - 8'd1;
            tmr.shutdown_due  = 1'b0;
            tmr.flash         = 1'b0;
         end else begin
            tmr.shutdown_due = 1'b1;
         end
      end
   endfunction

   // fold one accepted command into the model, return the status it yields
   function automatic result_type apply_command(item_type cmd);
      result_type status;
      status = '0;
      case (cmd.command)
         CMD_TICK: begin
            // prescaler zero behaves as one
            tmr.prescale = tmr.prescale + 8'd1;
            if (ticks_per_slow <= tmr.prescale) begin
               tmr.prescale     = '0;
               status.slow_tick = 1'b1;
               advance_slow_tick();
            end
         end
         CMD_START_TX: begin
            tmr.pacing  = '0;
            tmr.tx_busy = 1'b1;
         end
         CMD_START_RX: begin
            tmr.rx_left    = cmd.first_value;
            tmr.rx_active  = 1'b1;
            tmr.rx_success = 1'b0;
         end
         CMD_RX_SUCCESS: tmr.rx_success = 1'b1;
         CMD_START_LED: begin
            tmr.led_active   = 1'b1;
            tmr.delay_done   = 1'b0;
            tmr.delay_left   = cmd.first_value;
            tmr.toggles      = cmd.second_value;
            tmr.period       = cmd.flash_period;
            tmr.period_count = '0;
            tmr.flash        = 1'b0;
            tmr.change       = 1'b0;
         end
         // due flag only moves on the next slow tick
         CMD_LOAD_SHUTDOWN: tmr.shutdown_left = cmd.first_value;
         default: ;
      endcase
      status.power_on_done       = tmr.power_done;
      status.tx_busy             = tmr.tx_busy;
      status.rx_active           = tmr.rx_active;
      status.led_sequence_active = tmr.led_active;
      status.led_flash           = tmr.flash;
      status.led_change          = tmr.change;
      status.shutdown_due        = tmr.shutdown_due;
      return status;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // mostly short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // small values keep LED, rx and shutdown sequences short enough to finish
   function automatic logic [CountWidth-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return CountWidth'($urandom_range(0, 5));
      else if (r < 85)
         return CountWidth'($urandom_range(0, 255));
      return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
   endfunction

   function automatic item_type random_cmd(int unsigned tick_pct);
      item_type cmd;
      cmd.first_value  = pick_value();
      cmd.second_value = pick_value();
      cmd.flash_period = pick_value();
      if ($urandom_range(0, 99) < tick_pct)
         cmd.command = CMD_TICK;
      else begin
         case ($urandom_range(0, 11))
            0, 1:    cmd.command = CMD_START_TX;
            2, 3:    cmd.command = CMD_START_RX;
            4, 5:    cmd.command = CMD_RX_SUCCESS;
            6, 7:    cmd.command = CMD_START_LED;
            8, 9:    cmd.command = CMD_LOAD_SHUTDOWN;
            10:      cmd.command = CMD_SPARE_LO;
            default: cmd.command = CMD_SPARE_HI;
         endcase
      end
      return cmd;
   endfunction

   task automatic push_cmd(logic [CmdWidth-1:0] code, logic [CountWidth-1:0] first,
                           logic [CountWidth-1:0] second, logic [CountWidth-1:0] period);
      item_type cmd;
      cmd.command      = code;
      cmd.first_value  = first;
      cmd.second_value = second;
      cmd.flash_period = period;
      pending_cmds.push_back(cmd);
   endtask

   // sender holds off until every status is back, then the pipe settles
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_chan.valid || expected_status.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(logic [CountWidth-1:0] ticks, logic [CountWidth-1:0] pacing,
                                 logic [CountWidth-1:0] power);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FAST_TICKS_PER_SLOW;
      csr_write_data   <= ticks;
      ticks_per_slow    = ticks;
      @(posedge clock);
      csr_index        <= CSR_TX_PACING_LIMIT;
      csr_write_data   <= pacing;
      pacing_limit      = pacing;
      @(posedge clock);
      csr_index        <= CSR_POWER_ON_SLOW_TICKS;
      csr_write_data   <= power;
      power_on_ticks    = power;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(int unsigned count, int unsigned tick_pct, bit calm);
      @(negedge clock);
      steady = calm;
      repeat (count) pending_cmds.push_back(random_cmd(tick_pct));
      wait_idle();
   endtask

   task automatic report(string what, result_type want, result_type got);
      if (mismatches < REPORT_LIMIT)
         $display("%0t: %s: expected %b, got %b", $realtime, what, want, got);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // Driver: one command per transfer, model updated on accept
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      item_type next_cmd;
      item_type sent_cmd;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            sent_cmd.command      = req_chan.command;
            sent_cmd.first_value  = req_chan.first_value;
            sent_cmd.second_value = req_chan.second_value;
            sent_cmd.flash_period = req_chan.flash_period;
            expected_status.push_back(apply_command(sent_cmd));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               next_cmd               = pending_cmds.pop_front();
               req_chan.command      <= next_cmd.command;
               req_chan.first_value  <= next_cmd.first_value;
               req_chan.second_value <= next_cmd.second_value;
               req_chan.flash_period <= next_cmd.flash_period;
               req_chan.valid        <= 1'b1;
               send_gap <= (steady || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: random back-pressure, field-by-field check of each status
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.slow_tick, rsp_chan.power_on_done, rsp_chan.tx_busy,
                   rsp_chan.rx_active, rsp_chan.led_sequence_active, rsp_chan.led_flash,
                   rsp_chan.led_change, rsp_chan.shutdown_due};
            if (expected_status.size() == 0)
               report("status with nothing outstanding", '0, got);
            else begin
               want = expected_status.pop_front();
               for (int i = 0; i < 8; i++)
                  if (got[i] !== want[i])
                     report(status_fields[i], want, got);
            end
         end
         if (stall_left != 0) begin
            stall_left     <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 99) < 20) begin
            stall_left     <= pick_gap() - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of phases
   // ------------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_FAST_TICKS_PER_SLOW;
      csr_write_data        = '0;
      req_chan.valid        = 1'b0;
      req_chan.command      = CMD_TICK;
      req_chan.first_value  = '0;
      req_chan.second_value = '0;
      req_chan.flash_period = '0;
      rsp_chan.ready        = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: about one slow tick at the default divide of 50
      run_phase(60, 92, 1'b0);

      // directed: divide zero, pacing that never clears, power-on limit zero
      apply_settings(8'd0, 8'd255, 8'd0);
      @(negedge clock);
      push_cmd(CMD_START_TX, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_TICK, 8'hff, 8'hff, 8'hff);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      // rx timeout of zero ends on the next slow tick
      push_cmd(CMD_START_RX, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      // longest timeout, then success freezes it
      push_cmd(CMD_START_RX, 8'hff, 8'hff, 8'hff);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_RX_SUCCESS, 8'hff, 8'hff, 8'hff);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      // no delay, period zero, budget of two, then the budget runs out
      push_cmd(CMD_START_LED, 8'h00, 8'h02, 8'h00);
      repeat (5) push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      // shutdown count of one while idle, then due
      push_cmd(CMD_LOAD_SHUTDOWN, 8'h01, 8'h00, 8'h00);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      // spare codes do nothing
      push_cmd(CMD_SPARE_LO, 8'hff, 8'hff, 8'hff);
      push_cmd(CMD_SPARE_HI, 8'hff, 8'hff, 8'hff);
      // all-ones LED sequence blocks the shutdown countdown
      push_cmd(CMD_START_LED, 8'hff, 8'hff, 8'hff);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      wait_idle();

      apply_settings(8'd1, 8'd0, 8'd40);
      run_phase(30, 60, 1'b0);

      // back-to-back stretch: no gaps, no stalls
      apply_settings(8'd2, 8'd3, 8'd255);
      run_phase(30, 60, 1'b1);

      // widest divide: tick-heavy to get past the prescaler
      apply_settings(8'd255, 8'd254, 8'd1);
      run_phase(260, 97, 1'b0);

      apply_settings(8'd3, 8'd1, 8'd128);
      run_phase(20, 55, 1'b0);

      if (mismatches == 0 && expected_status.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
